>>> rtl/ehr_pkg.sv
// ----------------------------------------------------------------------------
// ehr_pkg
// Shared types and request codes for the event history ring.
// ----------------------------------------------------------------------------
package ehr_pkg;

  // request codes (s_tuser)
  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_CLEAR  = 3'd1;
  localparam logic [2:0] REQ_OLDER  = 3'd2;
  localparam logic [2:0] REQ_NEWER  = 3'd3;
  localparam logic [2:0] REQ_NEWEST = 3'd4;
  localparam logic [2:0] REQ_REMOVE = 3'd5;
  localparam logic [2:0] REQ_READ   = 3'd6;

  localparam int ENTRY_W = 67;

  // one log entry, stamp in the low bits
  typedef struct packed {
    logic signed [15:0] amount;
    logic        [7:0]  kind;
    logic signed [7:0]  origin;
    logic signed [2:0]  target;
    logic        [31:0] stamp;
  } entry_t;

  // one response
  typedef struct packed {
    logic               status;
    logic               entry_valid;
    entry_t             entry;
    logic        [5:0]  fill;
    logic signed [5:0]  cursor;
  } res_t;

endpackage

>>> rtl/ehr_mem.sv
// ----------------------------------------------------------------------------
// ehr_mem
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ehr_mem #(
  parameter int LOG_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(LOG_DEPTH)-1:0] waddr,
  input  ehr_pkg::entry_t              wdata,
  input  logic [$clog2(LOG_DEPTH)-1:0] raddr,
  output ehr_pkg::entry_t              rdata
);

  ehr_pkg::entry_t mem [LOG_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ehr_seq.sv
// ----------------------------------------------------------------------------
// ehr_seq
// Request sequencer: ring pointers, fill count, cursor, and the removal
// shift loop that walks newer entries down one slot per cycle.
// ----------------------------------------------------------------------------
module ehr_seq #(
  parameter int LOG_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_req,
  input  ehr_pkg::entry_t              in_entry,
  input  logic [4:0]                   in_pos,
  output logic                         res_valid,
  input  logic                         res_take,
  output ehr_pkg::res_t                res,
  output logic                         mem_we,
  output logic [$clog2(LOG_DEPTH)-1:0] mem_waddr,
  output ehr_pkg::entry_t              mem_wdata,
  output logic [$clog2(LOG_DEPTH)-1:0] mem_raddr,
  input  ehr_pkg::entry_t              mem_rdata
);

  localparam int AW = $clog2(LOG_DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(LOG_DEPTH - 1);
  localparam logic [AW:0]   FULL    = (AW+1)'(LOG_DEPTH);
  localparam logic [AW+1:0] DEPTH_W = (AW+2)'(LOG_DEPTH);
  localparam logic [AW+1:0] LAST_W  = (AW+2)'(LOG_DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_RD_WAIT  = 5'b00010,
    S_RM_HEAD  = 5'b00100,
    S_RM_SHIFT = 5'b01000,
    S_RESP     = 5'b10000
  } state_t;

  state_t          state, state_next;
  logic [AW-1:0]   wp, wp_next;
  logic [AW:0]     held, held_next;
  logic            sel_none, sel_none_next;
  logic [AW-1:0]   sel_idx, sel_idx_next;
  logic [AW-1:0]   cnt, cnt_next;
  logic [AW-1:0]   dst, dst_next;
  logic [AW-1:0]   src, src_next;
  logic            r_status, r_status_next;
  logic            r_ev, r_ev_next;
  ehr_pkg::entry_t r_entry, r_entry_next;

  logic [AW:0]     held_dec;
  logic [AW:0]     held_dec2;
  logic [AW-1:0]   sel_slot;
  logic [31:0]     pos32;
  logic [31:0]     held32;
  logic [31:0]     sel32;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] a);
    return (a == LAST) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] dec(input logic [AW-1:0] a);
    return (a == '0) ? LAST : a - 1'b1;
  endfunction

  // physical slot of position p counted from the newest entry
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] w,
                                         input logic [AW-1:0] p);
    logic [AW+1:0] t;
    t = {2'b00, w} + LAST_W - {2'b00, p};
    if (t >= DEPTH_W) begin
      t = t - DEPTH_W;
    end
    return t[AW-1:0];
  endfunction

  assign held_dec  = held - 1'b1;
  assign held_dec2 = held_dec - 1'b1;
  assign sel_slot  = slot(wp, sel_idx);
  assign pos32     = 32'(in_pos);
  assign held32    = 32'(held);
  assign sel32     = 32'(sel_idx);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_RESP);

  always_comb begin
    res.status      = r_status;
    res.entry_valid = r_ev;
    res.entry       = r_entry;
    res.fill        = held32[5:0];
    res.cursor      = sel_none ? 6'sh3F : sel32[5:0];
  end

  always_comb begin
    state_next    = state;
    wp_next       = wp;
    held_next     = held;
    sel_none_next = sel_none;
    sel_idx_next  = sel_idx;
    cnt_next      = cnt;
    dst_next      = dst;
    src_next      = src;
    r_status_next = r_status;
    r_ev_next     = r_ev;
    r_entry_next  = r_entry;
    mem_we        = 1'b0;
    mem_waddr     = wp;
    mem_wdata     = in_entry;
    mem_raddr     = src;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next    = S_RESP;
          r_status_next = 1'b0;
          r_ev_next     = 1'b0;
          r_entry_next  = '0;
          case (in_req)
            ehr_pkg::REQ_APPEND: begin
              if (in_entry.amount == '0) begin
                r_status_next = 1'b1;
              end else begin
                mem_we  = 1'b1;
                wp_next = inc(wp);
                if (held != FULL) begin
                  held_next = held + 1'b1;
                end
              end
            end
            ehr_pkg::REQ_CLEAR: begin
              held_next = '0;
              wp_next   = '0;
            end
            ehr_pkg::REQ_OLDER: begin
              if (held == '0) begin
                r_status_next = 1'b1;
              end else if (sel_none) begin
                sel_none_next = 1'b0;
                sel_idx_next  = '0;
              end else if (({1'b0, sel_idx} + 1'b1) < held) begin
                sel_idx_next = sel_idx + 1'b1;
              end
            end
            ehr_pkg::REQ_NEWER: begin
              if (held == '0) begin
                r_status_next = 1'b1;
              end else if (!sel_none && sel_idx != '0) begin
                sel_idx_next = sel_idx - 1'b1;
              end
            end
            ehr_pkg::REQ_NEWEST: begin
              if (held == '0) begin
                sel_none_next = 1'b1;
                r_status_next = 1'b1;
              end else begin
                sel_none_next = 1'b0;
                sel_idx_next  = '0;
              end
            end
            ehr_pkg::REQ_REMOVE: begin
              if (sel_none || {1'b0, sel_idx} >= held) begin
                r_status_next = 1'b1;
              end else begin
                mem_raddr  = sel_slot;
                cnt_next   = sel_idx;
                dst_next   = sel_slot;
                src_next   = inc(sel_slot);
                state_next = S_RM_HEAD;
              end
            end
            ehr_pkg::REQ_READ: begin
              if (pos32 >= held32) begin
                r_status_next = 1'b1;
              end else begin
                mem_raddr  = slot(wp, pos32[AW-1:0]);
                state_next = S_RD_WAIT;
              end
            end
            default: begin
              r_status_next = 1'b1;
            end
          endcase
        end
      end

      S_RD_WAIT: begin
        r_ev_next    = 1'b1;
        r_entry_next = mem_rdata;
        state_next   = S_RESP;
      end

      S_RM_HEAD: begin
        // removed entry arrives; read of the next newer one was issued above
        r_ev_next    = 1'b1;
        r_entry_next = mem_rdata;
        state_next   = S_RM_SHIFT;
      end

      S_RM_SHIFT: begin
        if (cnt != '0) begin
          mem_we    = 1'b1;
          mem_waddr = dst;
          mem_wdata = mem_rdata;
          dst_next  = src;
          src_next  = inc(src);
          mem_raddr = inc(src);
          cnt_next  = cnt - 1'b1;
        end
        if (cnt == '0 || cnt == AW'(1)) begin
          wp_next    = dec(wp);
          held_next  = held_dec;
          state_next = S_RESP;
          if (held_dec == '0) begin
            sel_none_next = 1'b1;
          end else if ({1'b0, sel_idx} >= held_dec) begin
            sel_idx_next = held_dec2[AW-1:0];
          end
        end
      end

      S_RESP: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wp       <= '0;
      held     <= '0;
      sel_none <= 1'b1;
      sel_idx  <= '0;
    end else begin
      state    <= state_next;
      wp       <= wp_next;
      held     <= held_next;
      sel_none <= sel_none_next;
      sel_idx  <= sel_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt      <= cnt_next;
    dst      <= dst_next;
    src      <= src_next;
    r_status <= r_status_next;
    r_ev     <= r_ev_next;
    r_entry  <= r_entry_next;
  end

endmodule

>>> rtl/event_history_ring_with_removal_core.sv
// ----------------------------------------------------------------------------
// event_history_ring_with_removal_core
// Bounded circular event log with cursor, read and remove-at-cursor.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: s_tuser carries the request code, s_tdata
// the entry fields and the read position. Every request produces exactly one
// transfer on the m_ stream: m_tuser flags status and entry presence, m_tdata
// carries the returned entry, the fill count and the cursor after the request.
// One request is in work at a time. Append, clear and cursor requests go
// straight to the response state, a read first waits in S_RD_WAIT for the
// registered memory data, and a remove at the cursor passes S_RM_HEAD and
// then S_RM_SHIFT, where each newer entry is moved down one slot per cycle
// through the single memory write port. The result is loaded into the
// output register from the response state; the next request is accepted
// while that result waits for m_tready.
// Synchronous reset empties the log, sets the cursor to none and drops any
// pending result; memory contents are not cleared and need no sweep.
// A stalled receiver holds the result in the output register; one more
// request is processed and its result parked, then s_tready stays low.
// ----------------------------------------------------------------------------
module event_history_ring_with_removal_core #(
  parameter int LOG_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // stamp[31:0], target[34:32], origin_id[42:35], kind[50:43],
  // amount[66:51], position[71:67]
  input  logic [71:0] s_tdata,
  // req_type[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_stamp[31:0], out_target[34:32], out_origin[42:35], out_kind[50:43],
  // out_amount[66:51], fill[72:67], cursor[78:73], zero[79]
  output logic [79:0] m_tdata,
  // status[0], entry_valid[1]
  output logic [1:0]  m_tuser
);

  localparam int AW = $clog2(LOG_DEPTH);

  ehr_pkg::entry_t in_entry;
  ehr_pkg::entry_t mem_wdata;
  ehr_pkg::entry_t mem_rdata;
  ehr_pkg::res_t   res;
  logic            res_valid;
  logic            res_take;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;

  always_comb begin
    in_entry.stamp  = s_tdata[31:0];
    in_entry.target = s_tdata[34:32];
    in_entry.origin = s_tdata[42:35];
    in_entry.kind   = s_tdata[50:43];
    in_entry.amount = s_tdata[66:51];
  end

  ehr_seq #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (s_tuser),
    .in_entry  (in_entry),
    .in_pos    (s_tdata[71:67]),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ehr_mem #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= {1'b0, res.cursor, res.fill, res.entry};
      m_tuser <= {res.entry_valid, res.status};
    end
  end

endmodule

>>> rtl/ehr_checker.sv
// ----------------------------------------------------------------------------
// ehr_checker
// Port-level checks for the event history ring, bound to the top level.
// ----------------------------------------------------------------------------
module ehr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // reset drops any pending result
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

  // a returned entry only comes with a done status
  a_entry_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0])
    else $error("entry returned on ignored request");

  // entry fields are zero when no entry is returned
  a_entry_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> (m_tdata[66:0] == 67'd0) && !m_tdata[79])
    else $error("entry fields not zero without entry");

  // one request in work at a time
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted back to back");

endmodule

bind event_history_ring_with_removal_core ehr_checker u_ehr_checker (.*);
